/* src/lmcd_pkg.sv */
// shared types and constants for the led matrix chain frame driver
package lmcd_pkg;

   localparam int ACTION_W  = 3;
   localparam int FIELD3_W  = 3;
   localparam int BYTE_W    = 8;
   localparam int OPCODE_W  = 4;
   localparam int WORD_W    = 16;
   localparam int CHAIN_W   = 4;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   localparam logic [BYTE_W-1:0] OP_NOOP     = 8'h00;
   localparam logic [BYTE_W-1:0] OP_COL_BASE = 8'h01;

   localparam logic [CHAIN_W-1:0] CHAIN_RESET = 4'd8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SET_LED       = 3'd0,
      ACT_SET_COLUMN    = 3'd1,
      ACT_SHOW          = 3'd2,
      ACT_CLEAR         = 3'd3,
      ACT_CONTROL_WRITE = 3'd4,
      ACT_READ_LED      = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_EMIT,
      ST_MODIFY,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] serial_word;
      logic              word_valid;
      logic              end_of_frame;
      logic              led_state;
      logic              last;
   } rsp_item_type;

endpackage

/* src/lmcd_ram.sv */
// generic single write port ram with registered read
module lmcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lmcd_out_reg.sv */
// output register stage for the result channel
module lmcd_out_reg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  lmcd_pkg::rsp_item_type               item,
   output logic                                 free,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lmcd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [lmcd_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);
   import lmcd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - WORD_W - 1){1'b0}}, item_ff.led_state,
                        item_ff.serial_word};
   assign rsp_tuser  = {item_ff.end_of_frame, item_ff.word_valid};
   assign rsp_tlast  = item_ff.last;

endmodule

/* src/lmcd_ctrl.sv */
// sequencer, frame store and word builder shared by all transactions
module lmcd_ctrl #(
   parameter int MAX_CHIPS        = 8,
   parameter int COLUMNS_PER_CHIP = 8,
   parameter int ROWS_PER_CHIP    = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lmcd_pkg::CHAIN_W-1:0]       chain_len,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lmcd_pkg::ACTION_W-1:0]      req_action,
   input  logic [lmcd_pkg::FIELD3_W-1:0]      req_device,
   input  logic [lmcd_pkg::FIELD3_W-1:0]      req_row,
   input  logic [lmcd_pkg::FIELD3_W-1:0]      req_column,
   input  logic                               req_led_on,
   input  logic [lmcd_pkg::BYTE_W-1:0]        req_column_bits,
   input  logic [lmcd_pkg::OPCODE_W-1:0]      req_control_register,
   input  logic [lmcd_pkg::BYTE_W-1:0]        req_control_value,
   input  logic                               out_free,
   output logic                               out_load,
   output lmcd_pkg::rsp_item_type             out_item
);
   import lmcd_pkg::*;

   localparam int DEPTH  = MAX_CHIPS * COLUMNS_PER_CHIP;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CHIP_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
   localparam int COL_W  = (COLUMNS_PER_CHIP > 1) ? $clog2(COLUMNS_PER_CHIP) : 1;
   localparam int IDX_W  = 2 * FIELD3_W;

   state_type state_ff, state_in;

   action_type               act_ff;
   logic [FIELD3_W-1:0]      dev_ff;
   logic [FIELD3_W-1:0]      row_ff;
   logic [COL_W-1:0]         col_ff;
   logic                     on_ff;
   logic [BYTE_W-1:0]        bits_ff;
   logic [BYTE_W-1:0]        op_ff;
   logic [BYTE_W-1:0]        data_ff;
   logic [CHIP_W-1:0]        pos_ff;
   logic                     led_ff;
   logic                     rd_valid_ff;
   logic [MAX_CHIPS-1:0]     dirty_ff;
   logic [MAX_CHIPS-1:0][COLUMNS_PER_CHIP-1:0] valid_ff;

   action_type               req_act;
   logic [CHAIN_W-1:0]       n_eff;
   logic                     dev_ok;
   logic                     row_ok;
   logic                     col_ok;
   logic                     accept;
   logic [IDX_W-1:0]         addr_wide;
   logic [ADDR_W-1:0]        addr;
   logic [BYTE_W-1:0]        ram_q;
   logic [BYTE_W-1:0]        stored;
   logic [FIELD3_W-1:0]      shift;
   logic [BYTE_W-1:0]        mask;
   logic [BYTE_W-1:0]        new_byte;
   logic                     ram_we;
   logic                     pos_is_dev;
   logic                     col_last;
   logic                     is_edit;

   assign req_act = action_type'(req_action);

   // chain length is clamped into one to MAX_CHIPS
   always_comb begin
      if (chain_len == '0) begin
         n_eff = CHAIN_W'(1);
      end else if (chain_len > CHAIN_W'(MAX_CHIPS)) begin
         n_eff = CHAIN_W'(MAX_CHIPS);
      end else begin
         n_eff = chain_len;
      end
   end

   assign dev_ok = {1'b0, req_device} < n_eff;
   assign row_ok = {1'b0, req_row} < (FIELD3_W + 1)'(ROWS_PER_CHIP);
   assign col_ok = {1'b0, req_column} < (FIELD3_W + 1)'(COLUMNS_PER_CHIP);

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;

   assign addr_wide = IDX_W'(dev_ff) * IDX_W'(COLUMNS_PER_CHIP) + IDX_W'(col_ff);
   assign addr      = addr_wide[ADDR_W-1:0];

   lmcd_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(addr),
      .wr_data(new_byte),
      .rd_addr(addr),
      .rd_data(ram_q)
   );

   // entries never written since reset or clear read as zero
   assign stored   = rd_valid_ff ? ram_q : '0;
   assign shift    = FIELD3_W'(ROWS_PER_CHIP - 1) - row_ff;
   assign mask     = BYTE_W'(1) << shift;
   assign new_byte = (act_ff == ACT_SET_COLUMN) ? bits_ff
                   : (on_ff ? (stored | mask) : (stored & ~mask));

   assign pos_is_dev = (FIELD3_W'(pos_ff) == dev_ff);
   assign col_last   = (col_ff == COL_W'(COLUMNS_PER_CHIP - 1));
   assign is_edit    = (act_ff == ACT_SET_LED) || (act_ff == ACT_SET_COLUMN)
                    || (act_ff == ACT_READ_LED);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_act)
                  ACT_SET_LED: begin
                     if (dev_ok && row_ok && col_ok) state_in = ST_FETCH;
                  end
                  ACT_SET_COLUMN: begin
                     if (dev_ok && col_ok) state_in = ST_FETCH;
                  end
                  ACT_READ_LED: begin
                     state_in = (dev_ok && row_ok && col_ok) ? ST_FETCH : ST_REPLY;
                  end
                  ACT_SHOW: begin
                     if (dev_ok && dirty_ff[req_device[CHIP_W-1:0]]) state_in = ST_FETCH;
                  end
                  ACT_CLEAR: begin
                     if (dev_ok) state_in = ST_FETCH;
                  end
                  ACT_CONTROL_WRITE: begin
                     if (dev_ok) state_in = ST_EMIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH:  state_in = is_edit ? ST_MODIFY : ST_LOAD;
         ST_LOAD:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free && pos_ff == '0) begin
               if (act_ff == ACT_CONTROL_WRITE || col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_MODIFY: state_in = (act_ff == ACT_READ_LED) ? ST_REPLY : ST_IDLE;
         ST_REPLY: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ram_we   = 1'b0;
      out_load = 1'b0;
      out_item = '0;
      unique case (state_ff)
         ST_EMIT: begin
            out_load                 = out_free;
            out_item.serial_word     = pos_is_dev ? {op_ff, data_ff} : {OP_NOOP, 8'h00};
            out_item.word_valid      = 1'b1;
            out_item.end_of_frame    = (pos_ff == '0);
            out_item.last            = (pos_ff == '0)
                                    && (act_ff == ACT_CONTROL_WRITE || col_last);
         end
         ST_MODIFY: begin
            ram_we = (act_ff != ACT_READ_LED);
         end
         ST_REPLY: begin
            out_load           = out_free;
            out_item.led_state = led_ff;
            out_item.last      = 1'b1;
         end
         default: begin
            ram_we   = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // dirty flags and entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= '0;
         valid_ff <= '0;
      end else begin
         if (accept && req_act == ACT_CLEAR && dev_ok) begin
            dirty_ff[req_device[CHIP_W-1:0]] <= 1'b1;
            valid_ff[req_device[CHIP_W-1:0]] <= '0;
         end
         if (ram_we) begin
            valid_ff[dev_ff[CHIP_W-1:0]][col_ff] <= 1'b1;
            if (new_byte != stored) begin
               dirty_ff[dev_ff[CHIP_W-1:0]] <= 1'b1;
            end
         end
         if (state_ff == ST_EMIT && out_free && pos_ff == '0 && col_last
             && act_ff == ACT_SHOW) begin
            dirty_ff[dev_ff[CHIP_W-1:0]] <= 1'b0;
         end
      end
   end

   // request fields and sequencing counters
   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[dev_ff[CHIP_W-1:0]][col_ff];
      if (accept) begin
         act_ff  <= req_act;
         dev_ff  <= req_device;
         row_ff  <= req_row;
         on_ff   <= req_led_on;
         bits_ff <= req_column_bits;
         op_ff   <= {{(BYTE_W - OPCODE_W){1'b0}}, req_control_register};
         data_ff <= req_control_value;
         pos_ff  <= CHIP_W'(n_eff - CHAIN_W'(1));
         led_ff  <= 1'b0;
         if (req_act == ACT_SHOW || req_act == ACT_CLEAR) begin
            col_ff <= '0;
         end else begin
            col_ff <= req_column[COL_W-1:0];
         end
      end
      if (state_ff == ST_LOAD) begin
         op_ff   <= OP_COL_BASE + BYTE_W'(col_ff);
         data_ff <= (act_ff == ACT_CLEAR) ? '0 : stored;
         pos_ff  <= CHIP_W'(n_eff - CHAIN_W'(1));
      end
      if (state_ff == ST_MODIFY) begin
         led_ff <= stored[shift];
      end
      if (state_ff == ST_EMIT && out_free) begin
         if (pos_ff == '0) begin
            if (!col_last) col_ff <= col_ff + 1'b1;
         end else begin
            pos_ff <= pos_ff - 1'b1;
         end
      end
   end

endmodule

/* src/led_matrix_chain_frame_driver_top.sv */
// top level of the led matrix chain frame driver
//
// channel  | direction | handshake            | payload
// req      | in        | req_tvalid/tready    | tuser action, tdata request fields
// rsp      | out       | rsp_tvalid/tready    | tdata word and led, tuser flags, tlast
// csr      | in        | csr_wr_en            | csr_wr_data chain length
//
// one request at a time; in-range edits pass fetch and modify, read_led adds a reply,
// control_write emits one word per chip in the chain, show and clear load and emit each
// column in turn via the single store read port, one word per cycle while rsp accepts
// requests that fail their checks emit nothing, an out-of-range read gives one reply
// a stalled rsp side holds the sequencer on the pending word
// reset clears all entry valid bits and dirty flags at once, no clearing pass
module led_matrix_chain_frame_driver_top #(
   parameter int MAX_CHIPS        = 8,
   parameter int COLUMNS_PER_CHIP = 8,
   parameter int ROWS_PER_CHIP    = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // device[2:0], row[5:3], column[8:6], led_on[9], column_bits[17:10],
   // control_register[21:18], control_value[29:22], zero pad
   input  logic [lmcd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action[2:0]
   input  logic [lmcd_pkg::ACTION_W-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // serial_word[15:0], led_state[16], zero pad
   output logic [lmcd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // word_valid[0], end_of_frame[1]
   output logic [lmcd_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [lmcd_pkg::CHAIN_W-1:0]       csr_wr_data
);
   import lmcd_pkg::*;

   logic [CHAIN_W-1:0] chain_ff;
   logic               out_free;
   logic               out_load;
   rsp_item_type       out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= CHAIN_RESET;
      end else if (csr_wr_en) begin
         chain_ff <= csr_wr_data;
      end
   end

   lmcd_ctrl #(
      .MAX_CHIPS       (MAX_CHIPS),
      .COLUMNS_PER_CHIP(COLUMNS_PER_CHIP),
      .ROWS_PER_CHIP   (ROWS_PER_CHIP)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .chain_len           (chain_ff),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_action          (req_tuser),
      .req_device          (req_tdata[2:0]),
      .req_row             (req_tdata[5:3]),
      .req_column          (req_tdata[8:6]),
      .req_led_on          (req_tdata[9]),
      .req_column_bits     (req_tdata[17:10]),
      .req_control_register(req_tdata[21:18]),
      .req_control_value   (req_tdata[29:22]),
      .out_free            (out_free),
      .out_load            (out_load),
      .out_item            (out_item)
   );

   lmcd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .item      (out_item),
      .free      (out_free),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
